### rtl/fwc_pkg.sv
package fwc_pkg;

	// queue geometry
	localparam int DEPTH    = 16;
	localparam int ID_BITS  = 16;
	localparam int ADDR_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W    = $clog2(DEPTH + 1);

	// fixed port widths
	localparam int KIND_W   = 2;
	localparam int STATUS_W = 2;
	localparam int PORT_ID_W = 16;
	localparam int FILL_W   = 5;

	// operation codes
	localparam logic [KIND_W-1:0] KIND_ENQ    = 2'd0;
	localparam logic [KIND_W-1:0] KIND_DEQ    = 2'd1;
	localparam logic [KIND_W-1:0] KIND_CANCEL = 2'd2;

	// status codes
	localparam logic [STATUS_W-1:0] ST_DONE     = 2'd0;
	localparam logic [STATUS_W-1:0] ST_EMPTY    = 2'd1;
	localparam logic [STATUS_W-1:0] ST_FULL     = 2'd2;
	localparam logic [STATUS_W-1:0] ST_NOTFOUND = 2'd3;

	typedef struct packed {
		logic [KIND_W-1:0]  kind;
		logic [ID_BITS-1:0] id;
	} fwc_cmd_t;

	typedef struct packed {
		logic [STATUS_W-1:0]  status;
		logic [PORT_ID_W-1:0] out_id;
		logic                 head_valid;
		logic [PORT_ID_W-1:0] head_id;
		logic [FILL_W-1:0]    fill_count;
	} fwc_rsp_t;

endpackage

### rtl/fifo_with_cancel_by_id.sv
// channel | handshake           | payload
// --------+---------------------+--------------------------------------------
// in      | in_valid, in_ready  | kind, item_id
// out     | out_valid, out_ready| status, out_id, head_valid, head_id, fill_count
//
// one word at a time: in_ready is high only while the sequencer is idle
// a cancel scans and shifts one entry a cycle, paced by the single
// read port of the slot store
// arst_n clears the sequencer, head index, fill count and output valid flag
// the result sits in an output register, so the next word is taken while it waits
// a stalled output holds the sequencer only once its next result is ready
module fifo_with_cancel_by_id (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [fwc_pkg::KIND_W-1:0]    kind,
	input  logic [fwc_pkg::PORT_ID_W-1:0] item_id,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [fwc_pkg::STATUS_W-1:0]  status,
	output logic [fwc_pkg::PORT_ID_W-1:0] out_id,
	output logic                         head_valid,
	output logic [fwc_pkg::PORT_ID_W-1:0] head_id,
	output logic [fwc_pkg::FILL_W-1:0]    fill_count
);
	import fwc_pkg::*;

	fwc_cmd_t    cmd;
	fwc_rsp_t    rsp;
	fwc_rsp_t    out_q;
	logic        out_valid_q;
	logic        core_idle;
	logic        rsp_valid;
	logic        rsp_ready;
	logic [31:0] id_w;

	// item_id is taken modulo the stored id width
	assign id_w     = 32'(item_id);
	assign cmd.kind = kind;
	assign cmd.id   = id_w[ID_BITS-1:0];

	assign in_ready = core_idle;

	// output register takes a result when empty or being drained
	assign rsp_ready = !out_valid_q || out_ready;

	fwc_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (in_valid && in_ready),
		.cmd       (cmd),
		.idle      (core_idle),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (rsp_ready) begin
			out_valid_q <= rsp_valid;
		end
	end

	// payload of the result word, no reset needed
	always_ff @(posedge clk) begin
		if (rsp_valid && rsp_ready) begin
			out_q <= rsp;
		end
	end

	assign out_valid  = out_valid_q;
	assign status     = out_q.status;
	assign out_id     = out_q.out_id;
	assign head_valid = out_q.head_valid;
	assign head_id    = out_q.head_id;
	assign fill_count = out_q.fill_count;

endmodule

### rtl/fwc_core.sv
module fwc_core (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  fwc_pkg::fwc_cmd_t cmd,
	output logic             idle,
	output logic             rsp_valid,
	input  logic             rsp_ready,
	output fwc_pkg::fwc_rsp_t rsp
);
	import fwc_pkg::*;

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_EXEC  = 3'd1;
	localparam logic [2:0] S_DEQ   = 3'd2;
	localparam logic [2:0] S_SCAN  = 3'd3;
	localparam logic [2:0] S_SHIFT = 3'd4;
	localparam logic [2:0] S_HEAD  = 3'd5;
	localparam logic [2:0] S_RESP  = 3'd6;

	localparam int SUM_W = CNT_W + 1;

	// circular slot store, one read and one write port
	logic [ID_BITS-1:0] mem [DEPTH];
	logic [ID_BITS-1:0] rdata_q;
	logic               rd_en;
	logic [ADDR_W-1:0]  rd_addr;
	logic               wr_en;
	logic [ADDR_W-1:0]  wr_addr;
	logic [ID_BITS-1:0] wr_data;

	logic [2:0]          st_q, st_d;
	logic [ADDR_W-1:0]   head_q, head_d;
	logic [CNT_W-1:0]    count_q, count_d;
	logic [CNT_W-1:0]    k_q, k_d;
	fwc_cmd_t            cmd_q, cmd_d;
	logic [STATUS_W-1:0] status_q, status_d;
	logic [ID_BITS-1:0]  removed_q, removed_d;

	logic [CNT_W-1:0]    scan_pos;
	logic [SUM_W-1:0]    nxt1;
	logic [SUM_W-1:0]    nxt2;
	logic [31:0]         removed_w;
	logic [31:0]         head_w;
	logic [31:0]         count_w;

	// slot index of head plus offset, offset below DEPTH
	function automatic logic [ADDR_W-1:0] wrap_add(input logic [ADDR_W-1:0] base,
			input logic [CNT_W-1:0] off);
		logic [SUM_W-1:0] sum;
		sum = SUM_W'(base) + SUM_W'(off);
		if (sum >= SUM_W'(DEPTH)) begin
			sum = sum - SUM_W'(DEPTH);
		end
		return sum[ADDR_W-1:0];
	endfunction

	// write data is the scanned id on a shift, the command id on enqueue
	assign wr_data = (st_q == S_SHIFT) ? rdata_q : cmd_q.id;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rdata_q <= mem[rd_addr];
		end
	end

	assign scan_pos = k_q - CNT_W'(1);
	assign nxt1     = SUM_W'(scan_pos) + SUM_W'(1);
	assign nxt2     = SUM_W'(k_q) + SUM_W'(2);

	always_comb begin
		st_d      = st_q;
		head_d    = head_q;
		count_d   = count_q;
		k_d       = k_q;
		cmd_d     = cmd_q;
		status_d  = status_q;
		removed_d = removed_q;
		rd_en     = 1'b0;
		rd_addr   = head_q;
		wr_en     = 1'b0;
		wr_addr   = head_q;
		case (st_q)
			S_IDLE: begin
				if (start) begin
					cmd_d     = cmd;
					status_d  = ST_DONE;
					removed_d = '0;
					st_d      = S_EXEC;
				end
			end
			S_EXEC: begin
				case (cmd_q.kind)
					KIND_ENQ: begin
						if (count_q == CNT_W'(DEPTH)) begin
							status_d = ST_FULL;
						end else begin
							wr_en   = 1'b1;
							wr_addr = wrap_add(head_q, count_q);
							count_d = count_q + CNT_W'(1);
						end
						st_d = S_HEAD;
					end
					KIND_DEQ: begin
						if (count_q == '0) begin
							status_d = ST_EMPTY;
							st_d     = S_HEAD;
						end else begin
							rd_en = 1'b1;
							st_d  = S_DEQ;
						end
					end
					KIND_CANCEL: begin
						if (count_q == '0) begin
							status_d = ST_NOTFOUND;
							st_d     = S_HEAD;
						end else begin
							rd_en = 1'b1;
							k_d   = CNT_W'(1);
							st_d  = S_SCAN;
						end
					end
					default: begin
						st_d = S_HEAD;
					end
				endcase
			end
			S_DEQ: begin
				removed_d = rdata_q;
				head_d    = wrap_add(head_q, CNT_W'(1));
				count_d   = count_q - CNT_W'(1);
				st_d      = S_HEAD;
			end
			S_SCAN: begin
				// rdata_q holds the entry at offset k_q - 1
				if (rdata_q == cmd_q.id) begin
					if (nxt1 < SUM_W'(count_q)) begin
						rd_en   = 1'b1;
						rd_addr = wrap_add(head_q, nxt1[CNT_W-1:0]);
						k_d     = scan_pos;
						st_d    = S_SHIFT;
					end else begin
						count_d = count_q - CNT_W'(1);
						st_d    = S_HEAD;
					end
				end else if (k_q < count_q) begin
					rd_en   = 1'b1;
					rd_addr = wrap_add(head_q, k_q);
					k_d     = k_q + CNT_W'(1);
				end else begin
					status_d = ST_NOTFOUND;
					st_d     = S_HEAD;
				end
			end
			S_SHIFT: begin
				// move entry k_q + 1 down into k_q
				wr_en   = 1'b1;
				wr_addr = wrap_add(head_q, k_q);
				k_d     = k_q + CNT_W'(1);
				if (nxt2 < SUM_W'(count_q)) begin
					rd_en   = 1'b1;
					rd_addr = wrap_add(head_q, nxt2[CNT_W-1:0]);
				end else begin
					count_d = count_q - CNT_W'(1);
					st_d    = S_HEAD;
				end
			end
			S_HEAD: begin
				rd_en = (count_q != '0);
				st_d  = S_RESP;
			end
			S_RESP: begin
				if (rsp_ready) begin
					st_d = S_IDLE;
				end
			end
			default: begin
				st_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q    <= S_IDLE;
			head_q  <= '0;
			count_q <= '0;
		end else begin
			st_q    <= st_d;
			head_q  <= head_d;
			count_q <= count_d;
		end
	end

	always_ff @(posedge clk) begin
		k_q       <= k_d;
		cmd_q     <= cmd_d;
		status_q  <= status_d;
		removed_q <= removed_d;
	end

	assign removed_w = 32'(removed_q);
	assign head_w    = (count_q != '0) ? 32'(rdata_q) : 32'd0;
	assign count_w   = 32'(count_q);

	assign idle      = (st_q == S_IDLE);
	assign rsp_valid = (st_q == S_RESP);

	always_comb begin
		rsp.status     = status_q;
		rsp.out_id     = removed_w[PORT_ID_W-1:0];
		rsp.head_valid = (count_q != '0);
		rsp.head_id    = head_w[PORT_ID_W-1:0];
		rsp.fill_count = count_w[FILL_W-1:0];
	end

endmodule

### rtl/fwc_checker.sv
module fwc_checker (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         in_valid,
	input logic                         in_ready,
	input logic                         out_valid,
	input logic                         out_ready,
	input logic [fwc_pkg::STATUS_W-1:0]  status,
	input logic [fwc_pkg::PORT_ID_W-1:0] out_id,
	input logic                         head_valid,
	input logic [fwc_pkg::PORT_ID_W-1:0] head_id,
	input logic [fwc_pkg::FILL_W-1:0]    fill_count
);
	import fwc_pkg::*;

	// a stalled result word holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(status) && $stable(out_id)
			&& $stable(head_id) && $stable(fill_count))
		else $error("result word changed while stalled");

	// one word at a time
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("second word taken while busy");

	a_head: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (head_valid == (fill_count != '0))
			&& (head_valid || head_id == '0))
		else $error("head flag disagrees with fill count");

	a_empty: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == ST_EMPTY |-> fill_count == '0 && out_id == '0)
		else $error("empty status with entries held");

	a_full: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == ST_FULL |-> fill_count == FILL_W'(DEPTH))
		else $error("full status below depth");

endmodule

bind fifo_with_cancel_by_id fwc_checker u_fwc_checker (.*);

### verif/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
	import fwc_pkg::*;

	// kind three has no operation behind it: the queue is left alone
	localparam logic [KIND_W-1:0] KIND_NOP = 2'd3;
	localparam int CYCLE_LIMIT = 600000;
	localparam int RANDOM_WORDS = 950;

	// bias of one random phase
	typedef enum int {MIX_FILL, MIX_DRAIN, MIX_CANCEL, MIX_EVEN} mix_t;

	// one word waiting to be sent, with the gap that follows it and an
	// optional hold until every result owed so far has come back
	typedef struct {
		logic [KIND_W-1:0]    op;
		logic [PORT_ID_W-1:0] id;
		int                   gap;
		bit                   drain;
	} word_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  in_valid = 1'b0;
	logic                  in_ready;
	logic [KIND_W-1:0]     kind = KIND_ENQ;
	logic [PORT_ID_W-1:0]  item_id = '0;
	logic                  out_valid;
	logic                  out_ready = 1'b0;
	logic [STATUS_W-1:0]   status;
	logic [PORT_ID_W-1:0]  out_id;
	logic                  head_valid;
	logic [PORT_ID_W-1:0]  head_id;
	logic [FILL_W-1:0]     fill_count;

	word_t    word_q[$];
	fwc_rsp_t owed_rsp_q[$];
	int       n_total = 0;
	int       n_sent = 0;
	int       n_recv = 0;
	int       errors = 0;
	int       cycles = 0;
	int       gap_left = 0;
	int       stall_left = 0;

	// shadow of the queue contents
	logic [PORT_ID_W-1:0] shadow_slot [DEPTH];
	int                   shadow_head = 0;
	int                   shadow_fill = 0;

	fifo_with_cancel_by_id DUT (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.kind       (kind),
		.item_id    (item_id),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.status     (status),
		.out_id     (out_id),
		.head_valid (head_valid),
		.head_id    (head_id),
		.fill_count (fill_count)
	);

	initial begin
		forever #10 clk = ~clk;
	end

	// applies one accepted word to the shadow queue and returns the response it owes
	function automatic fwc_rsp_t apply_word(logic [KIND_W-1:0] op, logic [PORT_ID_W-1:0] id);
		fwc_rsp_t rsp;
		int       hit;
		rsp = '0;
		rsp.status = ST_DONE;
		hit = -1;
		case (op)
			KIND_ENQ: begin
				if (shadow_fill >= DEPTH) begin
					rsp.status = ST_FULL;
				end else begin
					shadow_slot[(shadow_head + shadow_fill) % DEPTH] = id;
					shadow_fill++;
				end
			end
			KIND_DEQ: begin
				if (shadow_fill == 0) begin
					rsp.status = ST_EMPTY;
				end else begin
					rsp.out_id = shadow_slot[shadow_head];
					shadow_head = (shadow_head + 1) % DEPTH;
					shadow_fill--;
				end
			end
			KIND_CANCEL: begin
				// first match counting from the head wins
				for (int k = 0; k < shadow_fill; k++)
					if (hit < 0 && shadow_slot[(shadow_head + k) % DEPTH] == id)
						hit = k;
				if (hit < 0) begin
					rsp.status = ST_NOTFOUND;
				end else begin
					// close the gap, later entries move one step toward the head
					for (int j = hit; j + 1 < shadow_fill; j++)
						shadow_slot[(shadow_head + j) % DEPTH] =
							shadow_slot[(shadow_head + j + 1) % DEPTH];
					shadow_fill--;
				end
			end
			default: begin
				// unused kind: no change, plain done status
			end
		endcase
		rsp.head_valid = (shadow_fill != 0);
		rsp.head_id = (shadow_fill != 0) ? shadow_slot[shadow_head] : '0;
		rsp.fill_count = shadow_fill[FILL_W-1:0];
		return rsp;
	endfunction

	// idle length: mostly none or short, now and then long
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 40)
			return 0;
		else if (r < 85)
			return $urandom_range(1, 3);
		else if (r < 97)
			return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	function automatic void add_word(logic [KIND_W-1:0] op, logic [PORT_ID_W-1:0] id,
			int gap, bit drain);
		word_t w;
		w.op = op;
		w.id = id;
		w.gap = gap;
		w.drain = drain;
		word_q.push_back(w);
		n_total++;
	endfunction

	task automatic report(string field, int want, int got);
		$display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
		errors++;
	endtask

	// driver: presents the next word once the previous one is taken and its gap has run out
	always @(posedge clk or negedge arst_n) begin
		logic  fire;
		word_t w;
		if (!arst_n) begin
			in_valid <= 1'b0;
			kind <= KIND_ENQ;
			item_id <= '0;
			gap_left <= 0;
		end else begin
			fire = in_valid && in_ready;
			if (fire) begin
				owed_rsp_q.push_back(apply_word(kind, item_id));
				n_sent <= n_sent + 1;
			end
			if (!in_valid || fire) begin
				if (gap_left != 0) begin
					in_valid <= 1'b0;
					gap_left <= gap_left - 1;
				end else if (word_q.size() != 0 &&
						!(word_q[0].drain && (n_sent + int'(fire)) != n_recv)) begin
					w = word_q.pop_front();
					in_valid <= 1'b1;
					kind <= w.op;
					item_id <= w.id;
					gap_left <= w.gap;
				end else begin
					// nothing left, or holding until all responses are back
					in_valid <= 1'b0;
				end
			end
		end
	end

	// monitor: checks every response word against the oldest one owed
	always @(posedge clk or negedge arst_n) begin
		fwc_rsp_t want;
		bit       quiet;
		if (!arst_n) begin
			out_ready <= 1'b0;
			stall_left <= 0;
		end else begin
			if (out_valid && out_ready) begin
				n_recv <= n_recv + 1;
				if (owed_rsp_q.size() == 0) begin
					$display("%0t: response word with none expected, actual status %0h id %0h",
						$time, status, out_id);
					errors++;
				end else begin
					want = owed_rsp_q.pop_front();
					if (status !== want.status)
						report("status", want.status, status);
					if (out_id !== want.out_id)
						report("out_id", want.out_id, out_id);
					if (head_valid !== want.head_valid)
						report("head_valid", want.head_valid, head_valid);
					if (head_id !== want.head_id)
						report("head_id", want.head_id, head_id);
					if (fill_count !== want.fill_count)
						report("fill_count", want.fill_count, fill_count);
				end
			end
			// one window in four takes every response at once
			quiet = (cycles[11:10] == 2'b00);
			if (stall_left != 0) begin
				out_ready <= 1'b0;
				stall_left <= stall_left - 1;
			end else if (!quiet && $urandom_range(0, 99) < 30) begin
				out_ready <= 1'b0;
				stall_left <= pick_gap();
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("%0t: timeout, %0d of %0d responses seen", $time, n_recv, n_total);
			$display("tb_top: errors");
			$finish;
		end
	end

	initial begin
		mix_t                 mix;
		int                   len;
		int                   pct;
		int                   phase;
		bit                   calm;
		logic [PORT_ID_W-1:0] pool;
		logic [KIND_W-1:0]    op;
		logic [PORT_ID_W-1:0] id;

		for (int i = 0; i < DEPTH; i++)
			shadow_slot[i] = '0;

		// directed: empty cases, extremes of the id, duplicates, cancel at head and tail
		add_word(KIND_DEQ, 16'h1234, 0, 1'b0);
		add_word(KIND_CANCEL, 16'h1234, 1, 1'b0);
		add_word(KIND_NOP, 16'hFFFF, 0, 1'b0);
		add_word(KIND_ENQ, 16'h0000, 0, 1'b0);
		add_word(KIND_ENQ, 16'hFFFF, 2, 1'b0);
		add_word(KIND_ENQ, 16'h0000, 0, 1'b0);
		add_word(KIND_ENQ, 16'h5A5A, 0, 1'b0);
		add_word(KIND_CANCEL, 16'hBEEF, 0, 1'b0);
		add_word(KIND_CANCEL, 16'h0000, 3, 1'b0);
		add_word(KIND_NOP, 16'h0000, 0, 1'b0);
		add_word(KIND_DEQ, 16'h0000, 0, 1'b0);
		add_word(KIND_CANCEL, 16'h5A5A, 0, 1'b0);
		add_word(KIND_ENQ, 16'hA5A5, 0, 1'b0);
		add_word(KIND_DEQ, 16'hFFFF, 0, 1'b0);
		add_word(KIND_DEQ, 16'h0000, 0, 1'b0);
		add_word(KIND_CANCEL, 16'h0000, 0, 1'b0);

		// random phases; the first one fills the queue past full with nothing in between
		phase = 0;
		while (n_total < RANDOM_WORDS) begin
			mix = (phase == 0) ? MIX_FILL : mix_t'($urandom_range(0, 3));
			len = (phase == 0) ? 20 : $urandom_range(20, 60);
			calm = (phase == 0) || ($urandom_range(0, 3) == 0);
			// small id pool so cancels hit and duplicates appear
			pool = PORT_ID_W'($urandom);
			for (int i = 0; i < len; i++) begin
				pct = $urandom_range(0, 99);
				if (phase == 0)
					op = KIND_ENQ;
				else if (pct < 2)
					op = KIND_NOP;
				else begin
					case (mix)
						MIX_FILL:   op = (pct < 70) ? KIND_ENQ : (pct < 85) ? KIND_CANCEL : KIND_DEQ;
						MIX_DRAIN:  op = (pct < 60) ? KIND_DEQ : (pct < 80) ? KIND_ENQ : KIND_CANCEL;
						MIX_CANCEL: op = (pct < 50) ? KIND_CANCEL : (pct < 85) ? KIND_ENQ : KIND_DEQ;
						default:    op = (pct < 35) ? KIND_ENQ : (pct < 67) ? KIND_DEQ : KIND_CANCEL;
					endcase
				end
				if ($urandom_range(0, 3) == 0)
					id = PORT_ID_W'($urandom);
				else
					id = pool ^ PORT_ID_W'($urandom_range(0, 7));
				// sender holds until all responses are in at the start of every fifth phase
				add_word(op, id, calm ? 0 : pick_gap(), (i == 0) && (phase % 5 == 1));
			end
			phase++;
		end

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		while (n_recv != n_total)
			@(posedge clk);
		// a long cancel is the slowest word; let that much time pass for strays
		repeat (2 * DEPTH + 16) @(posedge clk);
		if (owed_rsp_q.size() != 0) begin
			$display("%0t: %0d expected responses never arrived", $time, owed_rsp_q.size());
			errors++;
		end
		if (errors == 0)
			$display("tb_top: clean");
		else
			$display("tb_top: errors");
		$finish;
	end

endmodule
